FILE: src/pscc_pkg.sv
// ---------------------------------------------------------------------------
// pscc_pkg
// shared widths, register indexes, limits and the sequencer state codes
// ---------------------------------------------------------------------------
package pscc_pkg;
    localparam int SpeedW   = 16;
    localparam int CurW     = 14;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 20;
    localparam int IntegW   = 40;

    localparam logic [CfgAddrW-1:0] RegKp     = 3'd0;
    localparam logic [CfgAddrW-1:0] RegKi     = 3'd1;
    localparam logic [CfgAddrW-1:0] RegPeriod = 3'd2;
    localparam logic [CfgAddrW-1:0] RegKf     = 3'd3;
    localparam logic [CfgAddrW-1:0] RegThr    = 3'd4;
    localparam logic [CfgAddrW-1:0] RegSteady = 3'd5;
    localparam logic [CfgAddrW-1:0] RegPlain  = 3'd6;

    localparam logic [1:0] PreloadLimit = 2'd3;
    localparam logic [CurW-1:0] CurrentMax = 14'd8960;

    localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
    localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

    localparam logic [19:0] UsPerS = 20'd1000000;

    // widths of the serial datapath
    localparam int MulW = 64;   // product register
    localparam int DivW = 64;   // dividend / divisor width
    localparam int CntW = 7;

    // sequencer states
    localparam int StW = 5;
    localparam logic [StW-1:0] StIdle    = 5'd0;
    localparam logic [StW-1:0] StKp      = 5'd1;
    localparam logic [StW-1:0] StPreNum  = 5'd2;
    localparam logic [StW-1:0] StPreNumW = 5'd3;
    localparam logic [StW-1:0] StPreDen  = 5'd4;
    localparam logic [StW-1:0] StPreDenW = 5'd5;
    localparam logic [StW-1:0] StIntMul  = 5'd6;
    localparam logic [StW-1:0] StIntMulW = 5'd7;
    localparam logic [StW-1:0] StIntDiv  = 5'd8;
    localparam logic [StW-1:0] StIntDivW = 5'd9;
    localparam logic [StW-1:0] StQMul    = 5'd10;
    localparam logic [StW-1:0] StQMulW   = 5'd11;
    localparam logic [StW-1:0] StRemMul  = 5'd12;
    localparam logic [StW-1:0] StRemMulW = 5'd13;
    localparam logic [StW-1:0] StRemDiv  = 5'd14;
    localparam logic [StW-1:0] StRemDivW = 5'd15;
    localparam logic [StW-1:0] StOut     = 5'd16;
endpackage

FILE: src/pscc_stream_if.sv
// ---------------------------------------------------------------------------
// pscc_stream_if
// valid/ready channel carrying a generic payload
// ---------------------------------------------------------------------------
interface pscc_stream_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: src/pi_speed_current_controller.sv
// ---------------------------------------------------------------------------
// pi_speed_current_controller
// PI speed controller with feed-forward, giving a motor current command
// ---------------------------------------------------------------------------
// usage:
//   one input transfer on s_in carries reference speed (bits 31:16) and measured
//   speed (bits 15:0), signed Q8.8; one output transfer on m_out carries drive
//   current (bits 15:2), feed-forward flag (bit 1) and preload flag (bit 0); the
//   user sees to it that the config port writes registers only while no sample
//   is in flight; the block itself does not enforce this
// datapath:
//   one sample at a time through a shared shift-add multiplier (one bit per
//   cycle, stopping early once the remaining multiplier bits are zero) and a
//   restoring divider; an integrator preload adds a multiply and a divide; the
//   next input can be taken in the cycle after the result is registered
// reset:
//   registers take their documented values, integrator and preload count clear
// stall:
//   the result stays in the output register until taken; a finished sample
//   waits for that register to free up, and input is held off until idle
// ---------------------------------------------------------------------------
module pi_speed_current_controller
    import pscc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    pscc_stream_if.sink         s_in,
    pscc_stream_if.source       m_out
);
    logic [15:0] r_kp, r_ki;
    logic [19:0] r_per;
    logic [13:0] r_kf, r_steady;
    logic [11:0] r_thr;
    logic        r_plain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0; r_ki <= '0; r_per <= 20'd1000; r_kf <= '0;
            r_thr <= 12'd256; r_steady <= '0; r_plain <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                RegKp:     r_kp     <= i_cfg_data[15:0];
                RegKi:     r_ki     <= i_cfg_data[15:0];
                RegPeriod: r_per    <= i_cfg_data;
                RegKf:     r_kf     <= i_cfg_data[13:0];
                RegThr:    r_thr    <= i_cfg_data[11:0];
                RegSteady: r_steady <= i_cfg_data[13:0];
                RegPlain:  r_plain  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [StW-1:0]           r_st;
    logic signed [IntegW-1:0] r_integ;
    logic [1:0]               r_pcnt;
    logic signed [16:0]       r_err;
    logic                     r_ff, r_pre, r_doit, r_neg;
    logic signed [63:0]       r_acc;     // kp*err plus integral term
    logic signed [63:0]       r_tmp;     // preload numerator
    logic [63:0]              r_mag, r_imag, r_rem;
    logic                     r_ovalid;
    logic [CurW+1:0]          r_odata;

    logic            m_start, d_start, m_done, d_done;
    logic [63:0]     m_a, m_b, m_p, d_n, d_d, d_q, d_r;

    logic signed [SpeedW-1:0] in_ref, in_meas;
    logic signed [16:0]       n_err;
    logic signed [IntegW:0]   n_isum;
    logic signed [IntegW-1:0] n_isat;
    logic signed [29:0]       n_lhs, n_rhs;
    logic                     n_above, n_ffb, n_doit, n_out_go;
    logic signed [33:0]       n_kperr;
    logic [35:0]              n_ki_per;
    logic [63:0]              n_abs_tmp, n_abs_integ, n_imag;
    logic signed [64:0]       n_pre_s;
    logic signed [63:0]       n_total;
    logic [55:0]              n_shr;
    logic [CurW-1:0]          n_cur;

    pscc_ser_mul u_mul (.i_clk, .i_rst_n, .i_start(m_start), .i_a(m_a), .i_b(m_b),
        .o_done(m_done), .o_p(m_p));
    pscc_ser_div u_div (.i_clk, .i_rst_n, .i_start(d_start), .i_num(d_n), .i_den(d_d),
        .o_done(d_done), .o_quo(d_q), .o_rem(d_r));

    assign in_ref   = s_in.data[31:16];
    assign in_meas  = s_in.data[15:0];
    assign n_err    = 17'(in_ref) - 17'(in_meas);
    assign n_isum   = 41'(r_integ) + 41'(n_err);
    assign n_isat   = (n_isum > 41'(IntegMax)) ? IntegMax :
                      (n_isum < 41'(IntegMin)) ? IntegMin : n_isum[IntegW-1:0];
    assign n_lhs    = 30'(in_meas) <<< 8;
    assign n_rhs    = $signed({18'd0, r_thr}) * 30'(in_ref);
    assign n_above  = n_lhs > n_rhs;
    assign n_ffb    = r_plain ? (in_ref > 16'sd0) : ((in_ref > 16'sd0) && !n_above);
    assign n_doit   = !r_plain && n_above && (r_pcnt < PreloadLimit) &&
                      (r_ki != '0) && (r_per != '0);
    assign n_kperr  = $signed({1'b0, r_kp}) * r_err;
    assign n_ki_per = 36'(r_ki) * 36'(r_per);

    assign n_abs_tmp   = r_tmp[63] ? 64'(-r_tmp) : 64'(r_tmp);
    assign n_abs_integ = r_integ[IntegW-1] ? 64'(-64'(r_integ)) : 64'(r_integ);
    assign n_pre_s     = r_neg ? -65'(d_q) : 65'(d_q);
    assign n_imag      = r_imag + d_q;

    assign n_total  = r_acc + (r_ff ? $signed(64'({r_kf, 8'd0})) : 64'sd0);
    assign n_shr    = n_total[63:8];
    assign n_cur    = (n_total <= 64'sd0) ? '0 :
                      (n_shr > 56'(CurrentMax)) ? CurrentMax : n_shr[CurW-1:0];
    assign n_out_go = (r_st == StOut) && (!r_ovalid || m_out.ready);

    always_comb begin
        m_start = 1'b0; d_start = 1'b0;
        m_a = '0; m_b = '0; d_n = '0; d_d = '0;
        unique case (r_st)
            StPreNum: begin
                m_start = 1'b1; m_a = n_abs_tmp; m_b = 64'(UsPerS);
            end
            StPreDen: begin
                d_start = 1'b1; d_n = r_mag; d_d = 64'(n_ki_per);
            end
            StIntMul: begin
                m_start = 1'b1; m_a = n_abs_integ; m_b = 64'(r_ki);
            end
            StIntDiv: begin
                d_start = 1'b1; d_n = r_mag; d_d = 64'(UsPerS);
            end
            StQMul: begin
                m_start = 1'b1; m_a = r_mag; m_b = 64'(r_per);
            end
            StRemMul: begin
                m_start = 1'b1; m_a = r_rem; m_b = 64'(r_per);
            end
            StRemDiv: begin
                d_start = 1'b1; d_n = r_mag; d_d = 64'(UsPerS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle; r_integ <= '0; r_pcnt <= '0;
        end else begin
            unique case (r_st)
                StIdle: if (s_in.valid) begin
                    r_err   <= n_err;
                    r_integ <= (r_ki == '0) ? '0 : n_isat;
                    r_ff    <= n_ffb;
                    r_doit  <= n_doit;
                    r_pre   <= 1'b0;
                    r_st    <= StKp;
                end
                StKp: begin
                    r_acc <= 64'(n_kperr);
                    r_tmp <= $signed(64'({r_steady, 8'd0})) - 64'(n_kperr);
                    r_st  <= r_doit ? StPreNum : StIntMul;
                end
                StPreNum: begin
                    r_neg <= r_tmp[63];
                    r_st  <= StPreNumW;
                end
                StPreNumW: if (m_done) begin
                    r_mag <= m_p;
                    r_st  <= StPreDen;
                end
                StPreDen: r_st <= StPreDenW;
                StPreDenW: if (d_done) begin
                    r_integ <= (n_pre_s > 65'(IntegMax)) ? IntegMax :
                               (n_pre_s < 65'(IntegMin)) ? IntegMin : n_pre_s[IntegW-1:0];
                    r_pcnt  <= r_pcnt + 2'd1;
                    r_pre   <= 1'b1;
                    r_st    <= StIntMul;
                end
                StIntMul: begin
                    r_neg <= r_integ[IntegW-1];
                    r_st  <= StIntMulW;
                end
                StIntMulW: if (m_done) begin
                    r_mag <= m_p;
                    r_st  <= StIntDiv;
                end
                StIntDiv: r_st <= StIntDivW;
                StIntDivW: if (d_done) begin
                    r_mag <= d_q;
                    r_rem <= d_r;
                    r_st  <= StQMul;
                end
                StQMul: r_st <= StQMulW;
                StQMulW: if (m_done) begin
                    r_imag <= m_p;
                    r_st   <= StRemMul;
                end
                StRemMul: r_st <= StRemMulW;
                StRemMulW: if (m_done) begin
                    r_mag <= m_p;
                    r_st  <= StRemDiv;
                end
                StRemDiv: r_st <= StRemDivW;
                StRemDivW: if (d_done) begin
                    r_acc <= r_neg ? r_acc - $signed(n_imag) : r_acc + $signed(n_imag);
                    r_st  <= StOut;
                end
                StOut: if (n_out_go) begin
                    r_st <= StIdle;
                end
                default: r_st <= StIdle;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (n_out_go) begin
            r_ovalid <= 1'b1;
            r_odata  <= {n_cur, r_ff, r_pre};
        end else if (m_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign s_in.ready   = (r_st == StIdle);
    assign m_out.valid  = r_ovalid;
    assign m_out.data   = r_odata;
endmodule

FILE: src/pscc_ser_mul.sv
// ---------------------------------------------------------------------------
// pscc_ser_mul
// shift-add multiplier, one multiplier bit per cycle, unsigned operands
// ---------------------------------------------------------------------------
module pscc_ser_mul
    import pscc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [MulW-1:0] i_a,
    input  logic [MulW-1:0] i_b,
    output logic            o_done,
    output logic [MulW-1:0] o_p
);
    logic [MulW-1:0] r_a, r_b, r_p;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_b[MulW-1:1] == '0 || r_cnt == CntW'(MulW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_b[MulW-1:1] == '0 || r_cnt == CntW'(MulW - 1));
    assign o_p    = r_b[0] ? r_p + r_a : r_p;
endmodule

FILE: src/pscc_ser_div.sv
// ---------------------------------------------------------------------------
// pscc_ser_div
// restoring divider, one quotient bit per cycle, unsigned operands
// ---------------------------------------------------------------------------
module pscc_ser_div
    import pscc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [DivW-1:0] i_num,
    input  logic [DivW-1:0] i_den,
    output logic            o_done,
    output logic [DivW-1:0] o_quo,
    output logic [DivW-1:0] o_rem
);
    logic [DivW-1:0] r_q, r_r, r_d;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic [DivW:0]   n_trial;
    logic [DivW:0]   n_shift;

    assign n_shift = {r_r, r_q[DivW-1]};
    assign n_trial = n_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CntW'(DivW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_busy) begin
            if (!n_trial[DivW]) begin
                r_r <= n_trial[DivW-1:0];
                r_q <= {r_q[DivW-2:0], 1'b1};
            end else begin
                r_r <= n_shift[DivW-1:0];
                r_q <= {r_q[DivW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_busy && r_cnt == CntW'(DivW - 1);
    assign o_quo  = {r_q[DivW-2:0], !n_trial[DivW]};
    assign o_rem  = n_trial[DivW] ? n_shift[DivW-1:0] : n_trial[DivW-1:0];
endmodule

FILE: tb/pscc_current_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pscc_current_checker
// watches the speed and current channels and the register port, computes
// the expected current command for each sample and compares it field by field
// ---------------------------------------------------------------------------
module pscc_current_checker
    import pscc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    pscc_stream_if              speed_ch,
    pscc_stream_if              current_ch,
    output int                  o_fail_count,
    output int                  o_pending
);
    typedef struct packed {
        logic [CurW-1:0] drive_current;
        logic            feedforward_active;
        logic            preload_applied;
    } t_command;

    localparam longint Q6Max  = 8960;
    localparam longint AccMax = 64'sd549755813887;
    localparam longint AccMin = -64'sd549755813888;
    localparam longint Micro  = 1000000;

    logic [15:0] kp_gain, ki_gain;
    logic [19:0] period_us;
    logic [13:0] kf_current, steady_current;
    logic [11:0] speed_thr;
    logic        plain_mode;
    longint      integ_acc;
    logic [1:0]  preloads_done;
    t_command    expected_cmds[$];

    function automatic longint clamp_acc(longint v);
        if (v > AccMax) return AccMax;
        if (v < AccMin) return AccMin;
        return v;
    endfunction

    // updates the integrator state and returns the expected command
    function automatic t_command predict_command(logic signed [15:0] ref_spd,
                                                 logic signed [15:0] meas_spd);
        longint   rs, ms, err, kp, ki, per, num, prod, total;
        logic     ff, pre, above;
        t_command cmd;
        rs = ref_spd;
        ms = meas_spd;
        err = rs - ms;
        kp = kp_gain;
        ki = ki_gain;
        per = period_us;
        pre = 1'b0;
        integ_acc = clamp_acc(integ_acc + err);
        if (ki == 0) integ_acc = 0;
        above = (ms * 256) > (longint'(speed_thr) * rs);
        if (!plain_mode) begin
            ff = (rs > 0) && !above;
            if (above && preloads_done < PreloadLimit && ki != 0 && per != 0) begin
                num = longint'(steady_current) * 256 - kp * err;
                integ_acc = clamp_acc((num * Micro) / (ki * per));
                preloads_done = preloads_done + 2'd1;
                pre = 1'b1;
            end
        end else begin
            ff = rs > 0;
        end
        prod = ki * integ_acc;
        total = kp * err + (prod / Micro) * per + ((prod % Micro) * per) / Micro;
        if (ff) total += longint'(kf_current) * 256;
        if (total <= 0) cmd.drive_current = '0;
        else if ((total >>> 8) > Q6Max) cmd.drive_current = CurrentMax;
        else cmd.drive_current = CurW'(total >>> 8);
        cmd.feedforward_active = ff;
        cmd.preload_applied = pre;
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        t_command got, want;
        int       errs;
        errs = 0;
        if (!i_rst_n) begin
            kp_gain <= '0;
            ki_gain <= '0;
            period_us <= 20'd1000;
            kf_current <= '0;
            speed_thr <= 12'd256;
            steady_current <= '0;
            plain_mode <= 1'b0;
            integ_acc = 0;
            preloads_done = '0;
            o_fail_count <= 0;
            o_pending <= 0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    RegKp: kp_gain <= i_cfg_data[15:0];
                    RegKi: ki_gain <= i_cfg_data[15:0];
                    RegPeriod: period_us <= i_cfg_data;
                    RegKf: kf_current <= i_cfg_data[13:0];
                    RegThr: speed_thr <= i_cfg_data[11:0];
                    RegSteady: steady_current <= i_cfg_data[13:0];
                    RegPlain: plain_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (speed_ch.valid && speed_ch.ready)
                expected_cmds.push_back(predict_command(speed_ch.data[31:16],
                                                        speed_ch.data[15:0]));
            if (current_ch.valid && current_ch.ready) begin
                got = current_ch.data;
                if (expected_cmds.size() == 0) begin
                    $error("unexpected current transfer %h", current_ch.data);
                    errs = errs + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.drive_current !== want.drive_current) begin
                        $error("drive_current expected %0d actual %0d",
                               want.drive_current, got.drive_current);
                        errs = errs + 1;
                    end
                    if (got.feedforward_active !== want.feedforward_active) begin
                        $error("feedforward_active expected %0b actual %0b",
                               want.feedforward_active, got.feedforward_active);
                        errs = errs + 1;
                    end
                    if (got.preload_applied !== want.preload_applied) begin
                        $error("preload_applied expected %0b actual %0b",
                               want.preload_applied, got.preload_applied);
                        errs = errs + 1;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
            o_pending <= expected_cmds.size();
        end
    end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// drives speed samples and register writes into the speed controller under
// varying handshake pressure; the checker judges every current transfer
// ---------------------------------------------------------------------------
module tb;
    import pscc_pkg::*;

    localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgAddrW-1:0] i_cfg_addr = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    int                  fail_count, pending;
    int                  send_idle_pct = 0, recv_idle_pct = 0, hold_cycles = 0;

    pscc_stream_if #(.W(32)) speed_ch ();
    pscc_stream_if #(.W(16)) current_ch ();

    always #6 i_clk = ~i_clk;

    pi_speed_current_controller dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_in(speed_ch.sink), .m_out(current_ch.source)
    );

    pscc_current_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .speed_ch(speed_ch), .current_ch(current_ch),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        speed_ch.valid = 1'b0;
        speed_ch.data = '0;
        current_ch.ready = 1'b0;
    end

    // receiver, with a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            current_ch.ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            current_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain();
        speed_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_gains(int kp, int ki, int per, int kf, int thr, int st, int pl);
        write_reg(RegKp, CfgDataW'(kp));
        write_reg(RegKi, CfgDataW'(ki));
        write_reg(RegPeriod, CfgDataW'(per));
        write_reg(RegKf, CfgDataW'(kf));
        write_reg(RegThr, CfgDataW'(thr));
        write_reg(RegSteady, CfgDataW'(st));
        write_reg(RegPlain, CfgDataW'(pl));
    endtask

    task automatic send_speed(logic [15:0] ref_spd, logic [15:0] meas_spd);
        while ($urandom_range(99) < send_idle_pct) begin
            speed_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        speed_ch.valid = 1'b1;
        speed_ch.data = {ref_spd, meas_spd};
        do @(posedge i_clk); while (!speed_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int r, m;
        if ($urandom_range(99) < 65) begin
            // tracking samples near the feed-forward threshold
            r = int'($urandom_range(6000)) - 1000;
            m = r * int'($urandom_range(300)) / 256 + int'($urandom_range(400)) - 200;
            send_speed(16'(r), 16'(m));
        end else begin
            send_speed(16'($urandom()), 16'($urandom()));
        end
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (3) @(negedge i_clk);

        // directed: preload saturation, skipped preloads, extremes, limit
        load_gains(256, 1, 1, 1000, 256, 8960, 0);
        send_speed(16'd1000, 16'd2000);
        write_reg(RegPeriod, 20'd0);
        send_speed(16'd1000, 16'd2000);
        write_reg(RegPeriod, 20'd1000000);
        write_reg(RegKi, 20'd0);
        send_speed(16'd1000, 16'd2000);
        write_reg(RegKi, 20'd65535);
        write_reg(RegPlain, 20'd1);
        send_speed(16'd1000, 16'd2000);
        send_speed(16'h8000, 16'h7fff);
        write_reg(RegPlain, 20'd0);
        write_reg(RegUnused, 20'hfffff);
        send_speed(16'd500, 16'd300);
        send_speed(16'h7fff, 16'h8000);
        send_speed(16'h8000, 16'h8000);
        send_speed(16'h7fff, 16'h7fff);
        send_speed(16'd0, 16'd0);
        send_speed(16'd1000, 16'd1200);
        send_speed(16'd1000, 16'd1500);
        send_speed(16'd1000, 16'd3000);
        load_gains(65535, 65535, 1000000, 8960, 4095, 0, 0);
        send_speed(16'h7fff, 16'h8000);
        send_speed(16'h8000, 16'h7fff);
        send_speed(16'd100, 16'd100);
        send_speed(16'hffff, 16'h0000);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: load_gains(0, 0, 1, 0, 0, 0, 0);
                5: load_gains(65535, 65535, 1000000, 8960, 4095, 8960, 1);
                default: load_gains($urandom_range(2000), $urandom_range(600),
                                    $urandom_range(1000000), $urandom_range(8960),
                                    $urandom_range(4095), $urandom_range(8960),
                                    $urandom_range(1));
            endcase
            send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 65 : 0;
            recv_idle_pct = (ph < 2) ? 65 : (ph < 4) ? 35 : 0;
            n = 140;
            for (int i = 0; i < n; i++) begin
                if (ph == 1 && i == 40) hold_cycles = 1500;
                if (ph == 3 && i == 70) drain();
                send_random();
            end
        end

        drain();
        repeat (500) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("pi_speed_current_controller regression: pass");
        else
            $display("pi_speed_current_controller regression: fail");
        $finish;
    end

    initial begin
        #40ms;
        $display("pi_speed_current_controller regression: fail");
        $finish;
    end
endmodule

FILE: pi_speed_current_controller.f
src/pscc_pkg.sv
src/pscc_stream_if.sv
src/pscc_ser_mul.sv
src/pscc_ser_div.sv
src/pi_speed_current_controller.sv
tb/pscc_current_checker.sv
tb/tb.sv
